[hdl/sret_pkg.sv]
package sret_pkg;

  localparam int TableDepth = 32;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam logic [1:0] OP_SIGNAL = 2'd0;
  localparam logic [1:0] OP_RATE   = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_DEAUTH = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [2:0] REG_LOW_RSSI  = 3'd0;
  localparam logic [2:0] REG_RATE_THR  = 3'd1;
  localparam logic [2:0] REG_IDLE_CHK  = 3'd2;
  localparam logic [2:0] REG_HITS      = 3'd3;
  localparam logic [2:0] REG_INACT     = 3'd4;
  localparam logic [2:0] REG_IDLE_LIM  = 3'd5;

  // One table entry as kept in the memory.
  typedef struct packed {
    logic [47:0] mac;
    logic [7:0]  sig;
    logic [7:0]  hits;
    logic [23:0] rate;
    logic        idle;
    logic [31:0] idle_since;
    logic [31:0] last_seen;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Result item handed to the output register.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [47:0] mac;
    logic [5:0]  dropped;
    logic        last;
  } result_t;

endpackage

[hdl/sret_ram.sv]
module sret_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/sret_out.sv]
module sret_out
  import sret_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t res,
  output logic    full,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  logic    valid_r;
  result_t data_r;

  // Single output register; the engine waits while it is occupied and not being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign full       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = data_r;

endmodule

[hdl/station_roam_eviction_table.sv]
// Station roam eviction table.
// Input channel in_*: one request per item; tdata holds operation, station_mac,
// signal_dbm, rate_kbps and now_seconds. Operation 0 and 1 are signal and rate
// reports, 2 runs an evaluate pass, 3 is ignored.
// Output channel out_*: tdata holds kind, status, victim_mac and dropped_count;
// tlast marks the final result of a request.
// Configuration channel cfg_*: register index and data, write while idle.
// A report walks all slots of the table memory, one read a cycle, then writes
// the entry. An evaluate pass makes two walks over the slots (drop by
// inactivity, then hit and idle update with eviction); an eviction holds the
// walk while its deauthenticate result is sent. The table memory has a single
// read port and a single write port; one request is in work at a time.
// At reset all slots read as empty and registers take their default values.
// A stalled receiver holds the single output register, and the engine waits
// until the held result is taken before it produces the next.
module station_roam_eviction_table
  import sret_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[1:0], station_mac[49:2], signal_dbm[57:50], rate_kbps[81:58],
  // now_seconds[113:82], zero fill up to 119.
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // kind[1:0], status[3:2], victim_mac[51:4], dropped_count[57:52], zero to 63.
  output logic [63:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_DROP  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [7:0] low_rssi_r;
  logic [15:0] rate_thr_r, inact_r, idle_lim_r;
  logic        idle_chk_r;
  logic [7:0]  hits_need_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_rssi_r  <= '0;
      rate_thr_r  <= 16'd2;
      idle_chk_r  <= 1'b1;
      hits_need_r <= 8'd6;
      inact_r     <= 16'd10;
      idle_lim_r  <= 16'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_RSSI:  low_rssi_r  <= cfg_data[7:0];
        REG_RATE_THR:  rate_thr_r  <= cfg_data;
        REG_IDLE_CHK:  idle_chk_r  <= cfg_data[0];
        REG_HITS:      hits_need_r <= cfg_data[7:0];
        REG_INACT:     inact_r     <= cfg_data;
        REG_IDLE_LIM:  idle_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request fields.
  logic [1:0]  op_r;
  logic [47:0] mac_r;
  logic [7:0]  sig_r;
  logic [23:0] rate_r;
  logic [31:0] now_r;

  // Walk control.
  logic [CntW-1:0]       cnt_r;       // slots read so far
  logic [TableDepth-1:0] valid_r, valid_nxt;
  logic                  hit_r, free_r;
  logic [SlotW-1:0]      hit_idx_r, free_idx_r;
  logic [5:0]            dropped_r;
  logic                  pend_r, pend_nxt;  // a read of an occupied slot is in flight
  logic [SlotW-1:0]      pend_idx_r;
  logic [47:0]           ev_mac_r;

  // Table memory.
  logic             ev_we;
  logic             ram_we;
  logic [SlotW-1:0] ram_waddr, raddr;
  entry_t           ram_wdata, rdata;

  sret_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata), .raddr, .rdata
  );

  // Output register.
  logic    push, out_full;
  result_t res, out_res;

  sret_out u_out (
    .clk, .rst_n, .push, .res, .full(out_full),
    .out_tvalid, .out_tready, .out_res
  );

  assign out_tdata = {6'd0, out_res.dropped, out_res.mac, out_res.status, out_res.kind};
  assign out_tlast = out_res.last;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Evaluate arithmetic on the entry read back.
  logic        weak_sig, idle_now, evict;
  logic [7:0]  hits_inc;
  logic [31:0] since_nxt;
  logic        low_rate;
  entry_t      upd;

  always_comb begin
    low_rate  = rdata.rate < {8'd0, rate_thr_r};
    hits_inc  = rdata.hits;
    weak_sig  = 1'b0;
    if ($signed(rdata.sig) < low_rssi_r) begin
      if (rdata.hits != 8'hFF) begin
        hits_inc = rdata.hits + 8'd1;
      end
      weak_sig = hits_inc >= hits_need_r;
    end
    since_nxt = rdata.idle_since;
    if (low_rate && !rdata.idle) begin
      since_nxt = now_r;
    end
    idle_now = low_rate && ((now_r - since_nxt) >= {16'd0, idle_lim_r});
    evict    = weak_sig && (idle_now || !idle_chk_r);
    upd            = rdata;
    upd.hits       = hits_inc;
    upd.idle       = low_rate;
    upd.idle_since = since_nxt;
  end

  logic stale;
  assign stale = (now_r - rdata.last_seen) > {16'd0, inact_r};

  logic scan_more;
  assign scan_more = cnt_r < CntW'(TableDepth);

  logic [SlotW-1:0] tgt;
  assign tgt = hit_r ? hit_idx_r : free_idx_r;

  // A walk state issues the next slot read unless an eviction holds it.
  logic walk_issue;
  assign walk_issue = (state_r == S_FIND) || (state_r == S_DROP) ||
                      ((state_r == S_EVAL) && !(pend_r && evict));

  always_comb begin
    state_nxt = state_r;
    ev_we     = 1'b0;
    raddr     = cnt_r[SlotW-1:0];
    push      = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tdata[1:0] == OP_SIGNAL || in_tdata[1:0] == OP_RATE) begin
            state_nxt = S_FIND;
          end else if (in_tdata[1:0] == OP_EVAL) begin
            state_nxt = (low_rssi_r == '0) ? S_DONE : S_DROP;
          end
        end
      end
      S_FIND: begin
        if (!scan_more && !pend_r) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!out_full) begin
          raddr = tgt;
          push  = 1'b1;
          res.kind   = KIND_ACK;
          res.mac    = mac_r;
          res.last   = 1'b1;
          res.status = hit_r ? ST_UPDATED : (free_r ? ST_ADDED : ST_FULL);
          state_nxt  = S_IDLE;
        end
      end
      S_DROP: begin
        if (!scan_more && !pend_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pend_r) begin
          ev_we = 1'b1;
          if (evict) begin
            state_nxt = S_EMIT;
          end
        end
        if (!scan_more && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_EMIT: begin
        if (!out_full) begin
          push      = 1'b1;
          res.kind  = KIND_DEAUTH;
          res.mac   = ev_mac_r;
          state_nxt = S_EVAL;
        end
      end
      S_DONE: begin
        if (!out_full) begin
          push        = 1'b1;
          res.kind    = KIND_DONE;
          res.dropped = dropped_r;
          res.last    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Next read flag and slot occupancy.
  always_comb begin
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    if (state_r == S_IDLE && in_acc) begin
      pend_nxt = 1'b0;
    end
    if (walk_issue) begin
      pend_nxt = scan_more ? valid_r[cnt_r[SlotW-1:0]] : 1'b0;
    end
    if (state_r == S_EVAL && pend_r && evict) begin
      pend_nxt              = 1'b0;
      valid_nxt[pend_idx_r] = 1'b0;
    end
    if (state_r == S_DROP && pend_r && stale) begin
      valid_nxt[pend_idx_r] = 1'b0;
    end
    if (state_r == S_WRITE && !out_full && (hit_r || free_r)) begin
      valid_nxt[tgt] = 1'b1;
    end
  end

  // Address of the station being evicted, for the deauthenticate result.
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL && pend_r && evict) begin
      ev_mac_r <= rdata.mac;
    end
  end

  // Sequencing registers.
  logic rep_we_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      pend_r   <= 1'b0;
      rep_we_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      pend_r   <= pend_nxt;
      rep_we_r <= (state_r == S_WRITE) && !out_full && (hit_r || free_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      op_r      <= in_tdata[1:0];
      mac_r     <= in_tdata[49:2];
      sig_r     <= in_tdata[57:50];
      rate_r    <= in_tdata[81:58];
      now_r     <= in_tdata[113:82];
      cnt_r     <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
      dropped_r <= '0;
    end
    if (walk_issue) begin
      if (scan_more) begin
        cnt_r      <= cnt_r + CntW'(1);
        pend_idx_r <= cnt_r[SlotW-1:0];
        if (state_r == S_FIND && !valid_r[cnt_r[SlotW-1:0]] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cnt_r[SlotW-1:0];
        end
      end else if (state_r == S_DROP && !pend_r) begin
        cnt_r <= '0;
      end
    end
    if (state_r == S_FIND && pend_r && !hit_r && rdata.mac == mac_r) begin
      hit_r     <= 1'b1;
      hit_idx_r <= pend_idx_r;
    end
    if (state_r == S_DROP && pend_r && stale) begin
      dropped_r <= dropped_r + 6'd1;
    end
  end

  // The hit entry is read in S_WRITE; the registered read data is merged in the write that follows.
  logic   rep_hit_r;
  logic [SlotW-1:0] rep_idx_r;
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      rep_hit_r <= hit_r;
      rep_idx_r <= tgt;
    end
  end

  // A new station starts from a fresh entry seen now.
  entry_t fresh, rep_base, rep_fin;
  always_comb begin
    fresh            = '0;
    fresh.mac        = mac_r;
    fresh.idle_since = now_r;
    fresh.last_seen  = now_r;
    rep_base = rep_hit_r ? rdata : fresh;
    rep_fin  = rep_base;
    if (op_r == OP_SIGNAL) begin
      rep_fin.sig       = sig_r;
      rep_fin.last_seen = now_r;
    end else begin
      rep_fin.rate = rate_r;
    end
  end

  // Final memory write port selection.
  assign ram_we    = rep_we_r | ev_we;
  assign ram_waddr = rep_we_r ? rep_idx_r : pend_idx_r;
  assign ram_wdata = rep_we_r ? rep_fin : upd;

endmodule

[bench/tb_station_roam_eviction_table.sv]
`timescale 1ns / 1ps

module tb_station_roam_eviction_table
  import sret_pkg::*;
();

  localparam int CycleLimit = 3000000;

  // One expected result as the output channel delivers it.
  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [47:0] mac;
    logic [5:0]  dropped;
    logic        last;
  } station_result_t;

  // Table predictor and the queue of results it still waits for.
  class eviction_scoreboard;
    logic signed [7:0] low_rssi;
    logic [15:0]       rate_thr;
    logic              idle_chk;
    logic [7:0]        hits_need;
    logic [15:0]       inact_lim;
    logic [15:0]       idle_lim;
    bit                valid[TableDepth];
    logic [47:0]       mac[TableDepth];
    logic signed [7:0] sig[TableDepth];
    logic [7:0]        hits[TableDepth];
    logic [23:0]       rate[TableDepth];
    bit                idle[TableDepth];
    logic [31:0]       idle_since[TableDepth];
    logic [31:0]       seen[TableDepth];
    station_result_t   pending[$];
    int                fails;

    function new();
      low_rssi  = 0;
      rate_thr  = 2;
      idle_chk  = 1;
      hits_need = 6;
      inact_lim = 10;
      idle_lim  = 20;
      fails     = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_LOW_RSSI:  low_rssi  = d[7:0];
        REG_RATE_THR:  rate_thr  = d;
        REG_IDLE_CHK:  idle_chk  = d[0];
        REG_HITS:      hits_need = d[7:0];
        REG_INACT:     inact_lim = d;
        REG_IDLE_LIM:  idle_lim  = d;
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] k, logic [1:0] st, logic [47:0] m,
                       logic [5:0] dr, logic l);
      station_result_t r;
      r.kind = k; r.status = st; r.mac = m; r.dropped = dr; r.last = l;
      pending.push_back(r);
    endfunction

    // Looks a station up, adds it in the lowest free slot, or reports full.
    function int find_or_add(logic [47:0] m, logic [31:0] now, output logic [1:0] st);
      for (int i = 0; i < TableDepth; i++)
        if (valid[i] && mac[i] == m) begin
          st = ST_UPDATED;
          return i;
        end
      for (int i = 0; i < TableDepth; i++)
        if (!valid[i]) begin
          valid[i] = 1; mac[i] = m; sig[i] = 0; hits[i] = 0; rate[i] = 0;
          idle[i] = 0; idle_since[i] = now; seen[i] = now;
          st = ST_ADDED;
          return i;
        end
      st = ST_FULL;
      return -1;
    endfunction

    function void note_request(logic [1:0] op, logic [47:0] m, logic signed [7:0] s,
                               logic [23:0] r, logic [31:0] now);
      logic [1:0]  st;
      logic [5:0]  dropped;
      logic [31:0] age;
      bit          faint, slow;
      int          slot;
      dropped = 0;
      if (op == OP_SIGNAL || op == OP_RATE) begin
        slot = find_or_add(m, now, st);
        if (slot >= 0) begin
          if (op == OP_SIGNAL) begin
            sig[slot] = s;
            seen[slot] = now;
          end else begin
            rate[slot] = r;
          end
        end
        push(KIND_ACK, st, m, 0, 1);
        return;
      end
      if (op != OP_EVAL) return;
      if (low_rssi == 0) begin
        push(KIND_DONE, 0, 0, 0, 1);
        return;
      end
      // First walk drops stations not heard from for too long.
      for (int i = 0; i < TableDepth; i++) begin
        age = now - seen[i];
        if (valid[i] && age > {16'd0, inact_lim}) begin
          valid[i] = 0;
          dropped++;
        end
      end
      // Second walk counts weak hits, tracks idleness and evicts.
      for (int i = 0; i < TableDepth; i++) begin
        if (!valid[i]) continue;
        faint = 0;
        slow = 0;
        if (sig[i] < low_rssi) begin
          if (hits[i] != 8'hFF) hits[i]++;
          if (hits[i] >= hits_need) faint = 1;
        end
        if (rate[i] < {8'd0, rate_thr}) begin
          if (!idle[i]) begin
            idle[i] = 1;
            idle_since[i] = now;
          end
          age = now - idle_since[i];
          if (age >= {16'd0, idle_lim}) slow = 1;
        end else begin
          idle[i] = 0;
        end
        if (faint && (slow || !idle_chk)) begin
          valid[i] = 0;
          push(KIND_DEAUTH, 0, mac[i], 0, 0);
        end
      end
      push(KIND_DONE, 0, 0, dropped, 1);
    endfunction

    function void check_result(logic [1:0] k, logic [1:0] st, logic [47:0] m,
                               logic [5:0] dr, logic l);
      station_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d mac=%h dropped=%0d last=%0d",
                 $time, k, st, m, dr, l);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== k || e.status !== st || e.mac !== m || e.dropped !== dr ||
          e.last !== l) begin
        $display("%0t: mismatch expected kind=%0d status=%0d mac=%h dropped=%0d last=%0d",
                 $time, e.kind, e.status, e.mac, e.dropped, e.last);
        $display("%0t:          actual   kind=%0d status=%0d mac=%h dropped=%0d last=%0d",
                 $time, k, st, m, dr, l);
        fails++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  eviction_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          recv_hold;
  int          cycles;
  logic [31:0] now_s;
  logic [47:0] mac_pool[40];

  station_roam_eviction_table uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Timeout guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[1:0], out_tdata[3:2], out_tdata[51:4],
                      out_tdata[57:52], out_tlast);

  // Receiver backpressure, with a long hold-off on demand.
  always @(negedge clk)
    out_tready <= recv_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

  task automatic set_idling(int mode);
    send_idle_pct  = (mode == 1) ? 79 : (mode == 3) ? 32 : 0;
    recv_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 32 : 0;
  endtask

  task automatic send_request(logic [1:0] op, logic [47:0] m, logic [7:0] s,
                              logic [23:0] r, logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, now, r, s, m, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, m, s, r, now);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic configure(logic [7:0] low, logic [15:0] rate, logic chk, logic [7:0] hits,
                           logic [15:0] inact, logic [15:0] idle);
    wait_drained();
    cfg_write(REG_LOW_RSSI, {8'd0, low});
    cfg_write(REG_RATE_THR, rate);
    cfg_write(REG_IDLE_CHK, {15'd0, chk});
    cfg_write(REG_HITS, {8'd0, hits});
    cfg_write(REG_INACT, inact);
    cfg_write(REG_IDLE_LIM, idle);
    cfg_valid <= 1'b0;
  endtask

  // Mostly reports from a small station pool, with evaluate passes mixed in.
  task automatic random_requests(int count, int pool_n);
    int          pick;
    logic [1:0]  op;
    logic [7:0]  s;
    logic [23:0] r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      op = (pick < 2) ? OP_UNUSED : (pick < 22) ? OP_EVAL : (pick < 62) ? OP_SIGNAL : OP_RATE;
      s = ($urandom_range(1) == 1) ? 8'($urandom_range(200, 150)) : 8'($urandom);
      r = ($urandom_range(1) == 1) ? 24'($urandom_range(3)) : 24'($urandom);
      now_s = now_s + $urandom_range(2);
      send_request(op, mac_pool[$urandom_range(pool_n - 1)], s, r, now_s);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    out_tready = 0;
    recv_hold = 0;
    now_s = 0;
    set_idling(0);
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < 40; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: field extremes, evaluation disabled, unused operation.
    send_request(OP_SIGNAL, '0, 8'h80, 24'd0, 32'd0);
    send_request(OP_SIGNAL, '1, 8'h7F, 24'hFFFFFF, 32'hFFFFFFFF);
    send_request(OP_RATE, '0, 8'h00, 24'hFFFFFF, 32'd1);
    send_request(OP_RATE, 48'h123456789ABC, 8'h00, 24'd0, 32'd2);
    send_request(OP_EVAL, '0, 8'h00, 24'd0, 32'd3);
    send_request(OP_UNUSED, '1, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    configure(8'(-50), 16'd2, 1'b0, 8'd1, 16'd10, 16'd0);
    // Weak on signal alone; the station reported at max time is not stale, as its age wraps round.
    send_request(OP_EVAL, '0, 8'h00, 24'd0, 32'd5);
    // Fill the table until it is full.
    for (int i = 0; i < 33; i++)
      send_request(OP_SIGNAL, {16'hA5A5, 32'(i)}, 8'd0, 24'd0, 32'd6);
    send_request(OP_EVAL, '0, 8'h00, 24'd0, 32'd200);

    // Random phases under several settings.
    now_s = 1000;
    configure(8'(-70), 16'd2, 1'b1, 8'd3, 16'd30, 16'd5);
    random_requests(40, 40);
    wait_drained();
    random_requests(30, 40);

    configure(8'(-128), 16'd1, 1'b1, 8'd1, 16'd65535, 16'd65535);
    set_idling(1);
    random_requests(40, 20);

    configure(8'(-1), 16'd65535, 1'b0, 8'd1, 16'd0, 16'd0);
    set_idling(2);
    random_requests(60, 20);

    configure(8'(-40), 16'd1000, 1'b1, 8'd255, 16'd65535, 16'd65535);
    set_idling(3);
    now_s = $urandom;
    random_requests(60, 20);

    // Near the time wrap, with one long receiver hold-off.
    configure(8'(-60), 16'd100, 1'b1, 8'd2, 16'd20, 16'd3);
    now_s = 32'hFFFFFFC0;
    set_idling(0);
    fork
      begin
        recv_hold = 1;
        repeat (800) @(negedge clk);
        recv_hold = 0;
      end
    join_none
    random_requests(60, 24);
    set_idling($urandom_range(3));
    random_requests(50, 24);

    wait_drained();
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
